>>> src/bbdr_pkg.sv
// Shared types and codes for the buck/boost duty regulator.
package bbdr_pkg;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_BUCK  = 2'd1,
    MODE_BOOST = 2'd2
  } bbdr_mode_e;

  localparam logic FUNC_START    = 1'b0;
  localparam logic FUNC_REGULATE = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_IN_SCALE   = 3'd1;
  localparam logic [2:0] REG_OUT_SCALE  = 3'd2;
  localparam logic [2:0] REG_BUCK_TGT   = 3'd3;
  localparam logic [2:0] REG_BOOST_TGT  = 3'd4;
  localparam logic [2:0] REG_FULL_SCALE = 3'd5;
  localparam logic [2:0] REG_FLOOR      = 3'd6;
  localparam logic [2:0] REG_CEILING    = 3'd7;

  localparam int unsigned CFG_W    = 18;
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned TARGET_W = 18;

  localparam logic [1:0]          RST_MODE       = 2'd0;
  localparam logic [SCALE_W-1:0]  RST_SCALE      = 16'd20601;
  localparam logic [TARGET_W-1:0] RST_BUCK_TGT   = 18'd5000;
  localparam logic [TARGET_W-1:0] RST_BOOST_TGT  = 18'd24000;
  localparam logic [15:0]         RST_FULL_SCALE = 16'd2047;
  localparam logic [15:0]         RST_FLOOR      = 16'd40;
  localparam logic [15:0]         RST_CEILING    = 16'd2006;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MULT,
    ST_DIV,
    ST_OUT
  } bbdr_state_e;

  typedef struct packed {
    logic load_in;
    logic scale;
    logic mult;
    logic div_step;
    logic load_out;
  } bbdr_cmd_t;

endpackage

>>> src/bbdr_ctrl.sv
// Sequencer for the regulator: scale, multiply, bit-serial divide, output.
module bbdr_ctrl import bbdr_pkg::*; #(
  parameter int unsigned NUM_W = 39
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bbdr_cmd_t cmd_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  bbdr_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             div_last;
  logic             out_free;

  assign div_last = (cnt_q == CNT_W'(NUM_W - 1));
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_SCALE;
      ST_SCALE: state_d = ST_MULT;
      ST_MULT:  state_d = ST_DIV;
      ST_DIV:   if (div_last) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_SCALE: cmd_o.scale = 1'b1;
      ST_MULT: begin
        cmd_o.mult = 1'b1;
        cnt_d      = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> src/bbdr_dpath.sv
// Datapath: code scaling, duty product, restoring divider, clamp and result register.
module bbdr_dpath import bbdr_pkg::*; #(
  parameter int unsigned CODE_BITS = 12,
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bbdr_cmd_t                   cmd_i,
  input  logic [1:0]                  mode_i,
  input  logic [SCALE_W-1:0]          in_scale_i,
  input  logic [SCALE_W-1:0]          out_scale_i,
  input  logic [TARGET_W-1:0]         buck_tgt_i,
  input  logic [TARGET_W-1:0]         boost_tgt_i,
  input  logic [DUTY_BITS-1:0]        full_scale_i,
  input  logic [DUTY_BITS-1:0]        floor_i,
  input  logic [DUTY_BITS-1:0]        ceiling_i,
  input  logic                        func_i,
  input  logic signed [CODE_BITS-1:0] in_code_i,
  input  logic signed [CODE_BITS-1:0] out_code_i,
  output logic [15:0]                 duty_o,
  output logic                        hit_floor_o,
  output logic                        hit_ceiling_o,
  output logic                        regulating_o
);

  localparam int unsigned MVP_W = CODE_BITS - 1 + SCALE_W;
  localparam int unsigned MV_W  = MVP_W - 8;
  localparam int unsigned DEN_W = (MV_W > TARGET_W) ? MV_W : TARGET_W;
  localparam int unsigned NUM_W = DUTY_BITS + DEN_W;

  logic                        func_q;
  logic signed [CODE_BITS-1:0] code_q;
  logic [MV_W-1:0]             mv_q;
  logic [NUM_W-1:0]            quo_q;
  logic [DEN_W-1:0]            den_q;
  logic [DEN_W-1:0]            rem_q;
  logic [DUTY_BITS-1:0]        duty_now_q;
  logic [15:0]                 duty_q;
  logic                        lo_q, hi_q, reg_q;

  logic [SCALE_W-1:0]   scale_sel;
  logic [MVP_W-1:0]     mv_prod;
  logic [MV_W-1:0]      mv_d;
  logic                 buck, active;
  logic [DUTY_BITS-1:0] mul_a;
  logic [DEN_W-1:0]     mul_b, den_sel;
  logic [NUM_W-1:0]     num_prod;
  logic [DEN_W:0]       trial, den_ext;
  logic                 ge;
  logic [DUTY_BITS-1:0] res_duty;
  logic                 res_lo, res_hi;

  assign scale_sel = func_q ? out_scale_i : in_scale_i;
  assign mv_prod   = MVP_W'(code_q[CODE_BITS-2:0]) * MVP_W'(scale_sel);
  // A negative code reads as zero millivolts.
  assign mv_d      = code_q[CODE_BITS-1] ? '0 : mv_prod[MVP_W-1:8];

  assign buck     = (mode_i == MODE_BUCK);
  assign active   = (mode_i == MODE_BUCK) || (mode_i == MODE_BOOST);
  assign mul_a    = (func_q == FUNC_REGULATE) ? duty_now_q : full_scale_i;
  assign mul_b    = buck ? DEN_W'(buck_tgt_i) : DEN_W'(mv_q);
  assign den_sel  = buck ? DEN_W'(mv_q) : DEN_W'(boost_tgt_i);
  assign num_prod = NUM_W'(mul_a) * NUM_W'(mul_b);

  assign trial   = {rem_q, quo_q[NUM_W-1]};
  assign den_ext = {1'b0, den_q};
  assign ge      = (trial >= den_ext);

  always_comb begin
    res_duty = '0;
    res_lo   = 1'b0;
    res_hi   = 1'b0;
    if (active) begin
      if (den_q == '0) begin
        res_duty = ceiling_i;
        res_hi   = 1'b1;
      end else if (quo_q < NUM_W'(floor_i)) begin
        res_duty = floor_i;
        res_lo   = 1'b1;
      end else if (quo_q > NUM_W'(ceiling_i)) begin
        res_duty = ceiling_i;
        res_hi   = 1'b1;
      end else begin
        res_duty = quo_q[DUTY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= func_i;
      code_q <= (func_i == FUNC_REGULATE) ? out_code_i : in_code_i;
    end
    if (cmd_i.scale) begin
      mv_q <= mv_d;
    end
    if (cmd_i.mult) begin
      quo_q <= num_prod;
      den_q <= den_sel;
      rem_q <= '0;
    end
    // The dividend shifts out at the top while quotient bits shift in below.
    if (cmd_i.div_step) begin
      rem_q <= ge ? DEN_W'(trial - den_ext) : trial[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
    if (cmd_i.load_out) begin
      duty_q <= 16'(res_duty);
      lo_q   <= res_lo;
      hi_q   <= res_hi;
      reg_q  <= active;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_now_q <= '0;
    end else if (cmd_i.load_out) begin
      duty_now_q <= res_duty;
    end
  end

  assign duty_o        = duty_q;
  assign hit_floor_o   = lo_q;
  assign hit_ceiling_o = hi_q;
  assign regulating_o  = reg_q;

endmodule

>>> src/buck_boost_duty_regulator.sv
// Top level of the buck/boost duty regulator: configuration registers, sequencer, datapath.
//
//   channel   signals                                          direction
//   input     in_valid_i, in_ready_o, func_i, in_code_i,       into block
//             out_code_i
//   output    out_valid_o, out_ready_i, duty_o, hit_floor_o,   out of block
//             hit_ceiling_o, regulating_o
//   config    cfg_we_i, cfg_idx_i, cfg_data_i                  into block
//
// One beat passes from acceptance through the scale, multiply, divide and output steps to a
// loaded result; the one-bit-per-cycle restoring divider works through a NUM_W-bit dividend,
// where NUM_W is DUTY_BITS + max(CODE_BITS + 7, 18). One beat is in work at a time.
// A new input beat is taken while a finished result waits in the output register; the
// result of that beat then holds in its last step until the output register is free.
// Reset clears the sequencer, the kept duty and the registers to their defaults.
module buck_boost_duty_regulator import bbdr_pkg::*; #(
  parameter int unsigned CODE_BITS = 12,
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic signed [CODE_BITS-1:0] in_code_i,
  input  logic signed [CODE_BITS-1:0] out_code_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [15:0]                 duty_o,
  output logic                        hit_floor_o,
  output logic                        hit_ceiling_o,
  output logic                        regulating_o
);

  localparam int unsigned MV_W  = CODE_BITS + 7;
  localparam int unsigned DEN_W = (MV_W > TARGET_W) ? MV_W : TARGET_W;
  localparam int unsigned NUM_W = DUTY_BITS + DEN_W;

  logic [1:0]           mode_q;
  logic [SCALE_W-1:0]   in_scale_q, out_scale_q;
  logic [TARGET_W-1:0]  buck_tgt_q, boost_tgt_q;
  logic [DUTY_BITS-1:0] full_scale_q, floor_q, ceiling_q;
  bbdr_cmd_t            cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= RST_MODE;
      in_scale_q   <= RST_SCALE;
      out_scale_q  <= RST_SCALE;
      buck_tgt_q   <= RST_BUCK_TGT;
      boost_tgt_q  <= RST_BOOST_TGT;
      full_scale_q <= RST_FULL_SCALE[DUTY_BITS-1:0];
      floor_q      <= RST_FLOOR[DUTY_BITS-1:0];
      ceiling_q    <= RST_CEILING[DUTY_BITS-1:0];
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE:       mode_q       <= cfg_data_i[1:0];
        REG_IN_SCALE:   in_scale_q   <= cfg_data_i[SCALE_W-1:0];
        REG_OUT_SCALE:  out_scale_q  <= cfg_data_i[SCALE_W-1:0];
        REG_BUCK_TGT:   buck_tgt_q   <= cfg_data_i[TARGET_W-1:0];
        REG_BOOST_TGT:  boost_tgt_q  <= cfg_data_i[TARGET_W-1:0];
        REG_FULL_SCALE: full_scale_q <= cfg_data_i[DUTY_BITS-1:0];
        REG_FLOOR:      floor_q      <= cfg_data_i[DUTY_BITS-1:0];
        REG_CEILING:    ceiling_q    <= cfg_data_i[DUTY_BITS-1:0];
        default: ;
      endcase
    end
  end

  bbdr_ctrl #(
    .NUM_W(NUM_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  bbdr_dpath #(
    .CODE_BITS(CODE_BITS),
    .DUTY_BITS(DUTY_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .mode_i       (mode_q),
    .in_scale_i   (in_scale_q),
    .out_scale_i  (out_scale_q),
    .buck_tgt_i   (buck_tgt_q),
    .boost_tgt_i  (boost_tgt_q),
    .full_scale_i (full_scale_q),
    .floor_i      (floor_q),
    .ceiling_i    (ceiling_q),
    .func_i       (func_i),
    .in_code_i    (in_code_i),
    .out_code_i   (out_code_i),
    .duty_o       (duty_o),
    .hit_floor_o  (hit_floor_o),
    .hit_ceiling_o(hit_ceiling_o),
    .regulating_o (regulating_o)
  );

`ifndef SYNTH
  // After an input beat the block is busy with it for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while a beat is in work");

  // Off mode gives an all-zero result.
  a_off_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !regulating_o |-> duty_o == 16'd0 && !hit_floor_o && !hit_ceiling_o)
    else $error("nonzero result while not regulating");

  // A result is clamped to one side at most.
  a_one_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_floor_o && hit_ceiling_o))
    else $error("both clamp flags set");
`endif

endmodule

>>> test/duty_regulator_checker.sv
// Result checker for the buck/boost duty regulator: predicts every result beat and compares.
module duty_regulator_checker import bbdr_pkg::*; #(
  parameter int unsigned CODE_BITS = 12,
  parameter int unsigned DUTY_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 func_i,
  input  logic [CODE_BITS-1:0] in_code_i,
  input  logic [CODE_BITS-1:0] out_code_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [15:0]          duty_i,
  input  logic                 hit_floor_i,
  input  logic                 hit_ceiling_i,
  input  logic                 regulating_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] DUTY_MASK  = 16'((32'd1 << DUTY_BITS) - 32'd1);
  localparam int unsigned MAX_PRINTS = 40;

  typedef struct packed {
    logic [15:0] duty;
    logic        hit_floor;
    logic        hit_ceiling;
    logic        regulating;
  } duty_beat_t;

  logic [1:0]           mode_q;
  logic [SCALE_W-1:0]   in_scale_q;
  logic [SCALE_W-1:0]   out_scale_q;
  logic [TARGET_W-1:0]  buck_tgt_q;
  logic [TARGET_W-1:0]  boost_tgt_q;
  logic [15:0]          full_scale_q;
  logic [15:0]          floor_q;
  logic [15:0]          ceiling_q;
  logic [DUTY_BITS-1:0] duty_now_q;
  duty_beat_t           duty_expected_q[$];
  duty_beat_t           want;
  int unsigned          fail_q = 0;

  // Negative codes read as zero volts; positive ones scale by a Q8 factor and truncate.
  function automatic logic [63:0] code_to_mv(logic [CODE_BITS-1:0] code,
                                             logic [SCALE_W-1:0] scale);
    if (code[CODE_BITS-1]) return 64'd0;
    return (64'(code) * 64'(scale)) >> 8;
  endfunction

  function automatic duty_beat_t next_duty(logic func, logic [CODE_BITS-1:0] in_code,
                                           logic [CODE_BITS-1:0] out_code);
    duty_beat_t  r;
    logic [63:0] vin;
    logic [63:0] vout;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quo;
    r = '0;
    if (mode_q != MODE_BUCK && mode_q != MODE_BOOST) return r;
    vin  = code_to_mv(in_code, in_scale_q);
    vout = code_to_mv(out_code, out_scale_q);
    if (func == FUNC_START) begin
      if (mode_q == MODE_BUCK) begin
        num = 64'(full_scale_q) * 64'(buck_tgt_q);
        den = vin;
      end else begin
        num = 64'(full_scale_q) * vin;
        den = 64'(boost_tgt_q);
      end
    end else begin
      if (mode_q == MODE_BUCK) begin
        num = 64'(duty_now_q) * 64'(buck_tgt_q);
        den = vout;
      end else begin
        num = 64'(duty_now_q) * vout;
        den = 64'(boost_tgt_q);
      end
    end
    r.regulating = 1'b1;
    if (den == 64'd0) begin
      r.duty        = ceiling_q;
      r.hit_ceiling = 1'b1;
    end else begin
      quo = num / den;
      // The floor test wins when the floor sits above the ceiling.
      if (quo < 64'(floor_q)) begin
        r.duty      = floor_q;
        r.hit_floor = 1'b1;
      end else if (quo > 64'(ceiling_q)) begin
        r.duty        = ceiling_q;
        r.hit_ceiling = 1'b1;
      end else begin
        r.duty = quo[15:0];
      end
    end
    r.duty = r.duty & DUTY_MASK;
    return r;
  endfunction

  // Printing stops after a while so that a broken block cannot flood the log; counting goes on.
  task automatic report_mismatch(string what);
    if (fail_q < MAX_PRINTS) $display("[%0t] duty result mismatch: %s", $time, what);
    fail_q++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       = RST_MODE;
      in_scale_q   = RST_SCALE;
      out_scale_q  = RST_SCALE;
      buck_tgt_q   = RST_BUCK_TGT;
      boost_tgt_q  = RST_BOOST_TGT;
      full_scale_q = RST_FULL_SCALE & DUTY_MASK;
      floor_q      = RST_FLOOR & DUTY_MASK;
      ceiling_q    = RST_CEILING & DUTY_MASK;
      duty_now_q   = '0;
      duty_expected_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (duty_expected_q.size() == 0) begin
          report_mismatch($sformatf("beat with nothing expected, duty %0d", duty_i));
        end else begin
          want = duty_expected_q.pop_front();
          if (duty_i !== want.duty)
            report_mismatch($sformatf("duty %0d, expected %0d", duty_i, want.duty));
          if (hit_floor_i !== want.hit_floor)
            report_mismatch($sformatf("hit_floor %b, expected %b", hit_floor_i,
                                      want.hit_floor));
          if (hit_ceiling_i !== want.hit_ceiling)
            report_mismatch($sformatf("hit_ceiling %b, expected %b", hit_ceiling_i,
                                      want.hit_ceiling));
          if (regulating_i !== want.regulating)
            report_mismatch($sformatf("regulating %b, expected %b", regulating_i,
                                      want.regulating));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want       = next_duty(func_i, in_code_i, out_code_i);
        duty_now_q = want.duty[DUTY_BITS-1:0];
        duty_expected_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:       mode_q       = cfg_data_i[1:0];
          REG_IN_SCALE:   in_scale_q   = cfg_data_i[SCALE_W-1:0];
          REG_OUT_SCALE:  out_scale_q  = cfg_data_i[SCALE_W-1:0];
          REG_BUCK_TGT:   buck_tgt_q   = cfg_data_i[TARGET_W-1:0];
          REG_BOOST_TGT:  boost_tgt_q  = cfg_data_i[TARGET_W-1:0];
          REG_FULL_SCALE: full_scale_q = cfg_data_i[15:0] & DUTY_MASK;
          REG_FLOOR:      floor_q      = cfg_data_i[15:0] & DUTY_MASK;
          REG_CEILING:    ceiling_q    = cfg_data_i[15:0] & DUTY_MASK;
          default: ;
        endcase
      end
    end
    fail_count_o <= fail_q;
    pending_o    <= duty_expected_q.size();
  end

endmodule

>>> test/tb_buck_boost_duty_regulator.sv
// Testbench top for the buck/boost duty regulator: clock, reset, stimulus and verdict.
module tb_buck_boost_duty_regulator import bbdr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CODE_BITS   = 12;
  localparam int unsigned DUTY_BITS   = 16;
  localparam int          CODE_MAX    = (2 ** (CODE_BITS - 1)) - 1;
  localparam int          CODE_MIN    = -(2 ** (CODE_BITS - 1));
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_BEATS = 86;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_LIMIT = 100000;
  localparam int unsigned SETTLE      = 60;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        cfg_we_i    = 1'b0;
  logic [2:0]                  cfg_idx_i   = REG_MODE;
  logic [CFG_W-1:0]            cfg_data_i  = '0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  logic                        func_i      = FUNC_START;
  logic signed [CODE_BITS-1:0] in_code_i   = '0;
  logic signed [CODE_BITS-1:0] out_code_i  = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic [15:0]                 duty_o;
  logic                        hit_floor_o;
  logic                        hit_ceiling_o;
  logic                        regulating_o;

  int unsigned fail_count;
  int unsigned pending_beats;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_seq       = 0;
  int unsigned hold_seen      = 0;
  int unsigned hold_left      = 0;

  // What the stimulus knows of the current settings, used to aim codes near the target.
  logic [1:0] cur_mode     = RST_MODE;
  longint     cur_in_scale = RST_SCALE;
  longint     cur_out_scale = RST_SCALE;
  longint     cur_buck_mv  = RST_BUCK_TGT;
  longint     cur_boost_mv = RST_BOOST_TGT;

  buck_boost_duty_regulator #(
    .CODE_BITS(CODE_BITS),
    .DUTY_BITS(DUTY_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .in_code_i    (in_code_i),
    .out_code_i   (out_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .duty_o       (duty_o),
    .hit_floor_o  (hit_floor_o),
    .hit_ceiling_o(hit_ceiling_o),
    .regulating_o (regulating_o)
  );

  duty_regulator_checker #(
    .CODE_BITS(CODE_BITS),
    .DUTY_BITS(DUTY_BITS)
  ) u_duty_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .func_i       (func_i),
    .in_code_i    (in_code_i),
    .out_code_i   (out_code_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .duty_i       (duty_o),
    .hit_floor_i  (hit_floor_o),
    .hit_ceiling_i(hit_ceiling_o),
    .regulating_i (regulating_o),
    .fail_count_o (fail_count),
    .pending_o    (pending_beats)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  task automatic load_config(logic [1:0] mode, int unsigned in_sc, int unsigned out_sc,
                             int unsigned buck_mv, int unsigned boost_mv,
                             int unsigned full, int unsigned floor_v, int unsigned ceil_v);
    cur_mode      = mode;
    cur_in_scale  = in_sc;
    cur_out_scale = out_sc;
    cur_buck_mv   = buck_mv;
    cur_boost_mv  = boost_mv;
    write_reg(REG_MODE, CFG_W'(mode));
    write_reg(REG_IN_SCALE, CFG_W'(in_sc));
    write_reg(REG_OUT_SCALE, CFG_W'(out_sc));
    write_reg(REG_BUCK_TGT, CFG_W'(buck_mv));
    write_reg(REG_BOOST_TGT, CFG_W'(boost_mv));
    write_reg(REG_FULL_SCALE, CFG_W'(full));
    write_reg(REG_FLOOR, CFG_W'(floor_v));
    write_reg(REG_CEILING, CFG_W'(ceil_v));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Valid is only dropped during an idle gap, never between two back-to-back beats.
  task automatic send_beat(logic func, logic signed [CODE_BITS-1:0] vin_code,
                           logic signed [CODE_BITS-1:0] vout_code);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    in_code_i  <= vin_code;
    out_code_i <= vout_code;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_beats != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
  endtask

  function automatic logic signed [CODE_BITS-1:0] code_near(longint mv, longint scale);
    longint c;
    if (scale == 0) return CODE_BITS'($urandom);
    c = mv * 256 / scale + longint'($urandom_range(8)) - 4;
    if (c > CODE_MAX) c = CODE_MAX;
    if (c < CODE_MIN) c = CODE_MIN;
    return CODE_BITS'(c);
  endfunction

  // A start beat aimed somewhere around the target, then a run of regulate beats whose
  // output voltage sits close to it, so the kept duty drifts instead of pinning at a limit.
  task automatic send_sequence(output int unsigned beats);
    longint                      tgt;
    int unsigned                 runs;
    logic signed [CODE_BITS-1:0] vin_c;
    logic signed [CODE_BITS-1:0] vout_c;
    tgt  = (cur_mode == MODE_BOOST) ? cur_boost_mv : cur_buck_mv;
    runs = $urandom_range(1, 8);
    if ($urandom_range(99) < 70)
      vin_c = code_near(tgt * $urandom_range(10, 1000) / 100, cur_in_scale);
    else
      vin_c = CODE_BITS'($urandom);
    send_beat(FUNC_START, vin_c, CODE_BITS'($urandom));
    repeat (runs) begin
      if ($urandom_range(99) < 80)
        vout_c = code_near(tgt * $urandom_range(80, 125) / 100, cur_out_scale);
      else
        vout_c = CODE_BITS'($urandom);
      send_beat(FUNC_REGULATE, CODE_BITS'($urandom), vout_c);
    end
    beats = runs + 1;
  endtask

  initial begin
    int unsigned sent;
    int unsigned seq_beats;
    int unsigned roll;
    logic [1:0]  pick_mode;
    bit          held;
    bit          paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the block is off, so every beat reads back as zero.
    send_beat(FUNC_START, 100, 100);
    send_beat(FUNC_REGULATE, CODE_MIN, CODE_MAX);
    drain();
    load_config(MODE_UNUSED, RST_SCALE, RST_SCALE, RST_BUCK_TGT, RST_BOOST_TGT,
                RST_FULL_SCALE, RST_FLOOR, RST_CEILING);
    send_beat(FUNC_START, CODE_MAX, CODE_MAX);
    drain();
    load_config(MODE_BUCK, RST_SCALE, RST_SCALE, RST_BUCK_TGT, RST_BOOST_TGT,
                RST_FULL_SCALE, RST_FLOOR, RST_CEILING);
    // Regulate with nothing seeded yet, then starts at zero and negative input voltage.
    send_beat(FUNC_REGULATE, 0, 62);
    send_beat(FUNC_START, 0, 0);
    send_beat(FUNC_START, -1, 0);
    send_beat(FUNC_START, CODE_MIN, 0);
    send_beat(FUNC_START, CODE_MAX, 0);
    send_beat(FUNC_REGULATE, 0, 0);
    send_beat(FUNC_REGULATE, 0, CODE_MAX);
    send_beat(FUNC_REGULATE, 0, CODE_MIN);
    send_beat(FUNC_START, 124, 0);
    send_beat(FUNC_REGULATE, 0, 62);
    drain();
    load_config(MODE_BOOST, RST_SCALE, RST_SCALE, RST_BUCK_TGT, RST_BOOST_TGT,
                RST_FULL_SCALE, RST_FLOOR, RST_CEILING);
    send_beat(FUNC_START, CODE_MAX, 0);
    send_beat(FUNC_START, 0, 0);
    send_beat(FUNC_START, CODE_MIN, 0);
    send_beat(FUNC_START, 150, 0);
    send_beat(FUNC_REGULATE, 0, 298);
    send_beat(FUNC_REGULATE, 0, CODE_MAX);
    send_beat(FUNC_REGULATE, 0, -1);
    drain();
    load_config(MODE_BUCK, 65535, 65535, 200000, 200000, 65535, 0, 65535);
    send_beat(FUNC_START, CODE_MAX, 0);
    send_beat(FUNC_REGULATE, 0, 1);
    send_beat(FUNC_REGULATE, 0, CODE_MAX);
    drain();
    load_config(MODE_BOOST, 65535, 65535, 200000, 1, 65535, 0, 65535);
    send_beat(FUNC_START, CODE_MAX, 0);
    // Floor set above the ceiling, with both voltage scales at zero.
    drain();
    load_config(MODE_BUCK, 0, 0, 0, 1, 1, 65535, 0);
    send_beat(FUNC_START, 100, 0);
    send_beat(FUNC_REGULATE, 0, 5);
    drain();
    load_config(MODE_BOOST, 0, 0, 0, 1, 1, 65535, 0);
    send_beat(FUNC_START, 5, 0);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: load_config(MODE_BUCK, RST_SCALE, RST_SCALE, RST_BUCK_TGT, RST_BOOST_TGT,
                       RST_FULL_SCALE, RST_FLOOR, RST_CEILING);
        1: load_config(MODE_BOOST, RST_SCALE, RST_SCALE, RST_BUCK_TGT, RST_BOOST_TGT,
                       RST_FULL_SCALE, RST_FLOOR, RST_CEILING);
        6: load_config(MODE_BUCK, 65535, 65535, 200000, 200000, 65535, 0, 65535);
        default: begin
          roll = $urandom_range(99);
          if (roll < 45)      pick_mode = MODE_BUCK;
          else if (roll < 90) pick_mode = MODE_BOOST;
          else if (roll < 95) pick_mode = MODE_OFF;
          else                pick_mode = MODE_UNUSED;
          load_config(pick_mode, $urandom_range(65535), $urandom_range(65535),
                      $urandom_range(200000), $urandom_range(1, 200000),
                      $urandom_range(1, 65535), $urandom_range(4000), $urandom_range(65535));
        end
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 75;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 75;
        end
        default: begin
          send_idle_pct  = 11;
          recv_stall_pct = 11;
        end
      endcase
      sent = 0;
      while (sent < PHASE_BEATS) begin
        // The result side holds off for a long stretch while beats keep coming.
        if (phase == 2 && sent >= 10 && !held) begin
          held = 1'b1;
          hold_seq++;
        end
        if (phase == 5 && sent >= 40 && !paused) begin
          paused = 1'b1;
          drain();
        end
        if ($urandom_range(99) < 15) begin
          send_beat(1'($urandom), CODE_BITS'($urandom), CODE_BITS'($urandom));
          sent++;
        end else begin
          send_sequence(seq_beats);
          sent += seq_beats;
        end
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && pending_beats == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
